// ===== rtl/cseg_pkg.sv =====
// Shared types and constants for the control segment deframer.
package cseg_pkg;

  localparam int MAX_PACKET = 1500;
  localparam int LIM_BASE = MAX_PACKET - 23;
  localparam int HDR_BYTES = 9;
  localparam int LAST_HDR_OFF = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PLAIN
  } phase_e;

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_PAYLOAD,
    OP_SWITCH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             is_plain;
    logic [7:0]       seg_type;
    logic [10:0]      seg_length;
    logic             truncated;
    logic [7:0]       data;
    logic             seg_end;
    logic [1:0]       n_held;
    logic [2:0][7:0]  held;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== rtl/cseg_front.sv =====
// Front part: accepts payload bytes, tracks segment parsing and queues result descriptors.
module cseg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  magic_word_we_i,
  input  logic [31:0]           magic_word_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic [10:0]           packet_len_i,
  input  logic                  full_i,
  output cseg_pkg::push_t       push_o
);

  logic [31:0]           magic_q;
  logic [10:0]           pos_q, pos_d;
  logic [10:0]           start_q, start_d;
  cseg_pkg::phase_e      phase_q, phase_d;
  logic [2:0][7:0]       held_q, held_d;
  logic [7:0]            type_q, type_d;
  logic [31:0]           decl_q, decl_d;
  logic [10:0]           left_q, left_d;

  logic                  accept;
  logic [11:0]           pos_inc;
  logic                  pkt_end;
  logic [10:0]           start_eff;
  logic [10:0]           diff;
  logic [3:0]            off;
  logic [7:0]            want;
  logic                  mismatch;
  logic [31:0]           decl_new;
  logic [31:0]           lim;
  logic [31:0]           clamped;
  logic [10:0]           rem;
  logic [10:0]           hdr_len;
  logic [10:0]           plain_len;
  logic [10:0]           left_dec;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  assign pos_inc   = {1'b0, pos_q} + 12'd1;
  assign pkt_end   = pos_inc >= {1'b0, packet_len_i};
  assign start_eff = (start_q > pos_q) ? pos_q : start_q;
  assign diff      = pos_q - start_eff;
  assign off       = (diff > 11'(cseg_pkg::LAST_HDR_OFF)) ? 4'(cseg_pkg::LAST_HDR_OFF)
                                                          : diff[3:0];

  always_comb begin
    case (off[1:0])
      2'd0:    want = magic_q[31:24];
      2'd1:    want = magic_q[23:16];
      2'd2:    want = magic_q[15:8];
      default: want = magic_q[7:0];
    endcase
  end

  assign mismatch = (off < 4'd4) &&
                    (((off == 4'd0) && (packet_len_i < 11'(cseg_pkg::HDR_BYTES))) ||
                     (data_byte_i != want));

  assign decl_new = {decl_q[23:0], data_byte_i};
  assign lim      = (32'(start_eff) >= 32'(cseg_pkg::LIM_BASE)) ? 32'd0
                    : 32'(cseg_pkg::LIM_BASE) - 32'(start_eff);
  assign clamped  = (decl_new > lim) ? lim : decl_new;
  assign rem      = pkt_end ? 11'd0 : packet_len_i - pos_inc[10:0];
  assign hdr_len  = (clamped < 32'(rem)) ? clamped[10:0] : rem;
  assign plain_len = pkt_end ? 11'(off) + 11'd1 : packet_len_i - start_eff;
  assign left_dec = (left_q != 11'd0) ? left_q - 11'd1 : 11'd0;

  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    phase_d = phase_q;
    held_d  = held_q;
    type_d  = type_q;
    decl_d  = decl_q;
    left_d  = left_q;
    push_o  = '0;
    push_o.entry.held = held_q;
    push_o.entry.data = data_byte_i;
    if (accept) begin
      case (phase_q)
        cseg_pkg::PH_HEADER: begin
          if (off < 4'd4) begin
            if (mismatch) begin
              push_o.push             = 1'b1;
              push_o.entry.op         = cseg_pkg::OP_SWITCH;
              push_o.entry.is_plain   = 1'b1;
              push_o.entry.seg_length = plain_len;
              push_o.entry.seg_end    = pkt_end;
              push_o.entry.n_held     = off[1:0];
              phase_d                 = cseg_pkg::PH_PLAIN;
            end else if (off < 4'd3) begin
              held_d[off[1:0]] = data_byte_i;
            end
          end else if (off == 4'd4) begin
            type_d = data_byte_i;
          end else if (off == 4'd5) begin
            decl_d = 32'(data_byte_i);
          end else begin
            decl_d = decl_new;
          end
          if (!mismatch) begin
            if (off == 4'(cseg_pkg::LAST_HDR_OFF)) begin
              push_o.push             = 1'b1;
              push_o.entry.op         = cseg_pkg::OP_HEADER;
              push_o.entry.seg_type   = type_q;
              push_o.entry.seg_length = hdr_len;
              if (hdr_len == 11'd0) begin
                start_d = pos_inc[10:0];
              end else begin
                left_d  = hdr_len;
                phase_d = cseg_pkg::PH_PAYLOAD;
              end
            end else if (pkt_end) begin
              push_o.push            = 1'b1;
              push_o.entry.op        = cseg_pkg::OP_HEADER;
              push_o.entry.truncated = 1'b1;
              if (off == 4'd4) begin
                push_o.entry.seg_type = data_byte_i;
              end else if (off > 4'd4) begin
                push_o.entry.seg_type = type_q;
              end
            end
          end
        end
        cseg_pkg::PH_PAYLOAD: begin
          push_o.push          = 1'b1;
          push_o.entry.op      = cseg_pkg::OP_PAYLOAD;
          push_o.entry.seg_end = (left_dec == 11'd0) || pkt_end;
          left_d               = left_dec;
          if (left_dec == 11'd0) begin
            phase_d = cseg_pkg::PH_HEADER;
            start_d = pos_inc[10:0];
          end
        end
        cseg_pkg::PH_PLAIN: begin
          push_o.push           = 1'b1;
          push_o.entry.op       = cseg_pkg::OP_PAYLOAD;
          push_o.entry.is_plain = 1'b1;
          push_o.entry.seg_end  = pkt_end;
        end
        default: begin
          phase_d = cseg_pkg::PH_HEADER;
        end
      endcase
      if (pkt_end) begin
        pos_d   = '0;
        start_d = '0;
        phase_d = cseg_pkg::PH_HEADER;
        left_d  = '0;
      end else begin
        pos_d = pos_inc[10:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
      pos_q   <= '0;
      start_q <= '0;
      phase_q <= cseg_pkg::PH_HEADER;
      type_q  <= '0;
      decl_q  <= '0;
      left_q  <= '0;
    end else begin
      if (magic_word_we_i) begin
        magic_q <= magic_word_i;
      end
      pos_q   <= pos_d;
      start_q <= start_d;
      phase_q <= phase_d;
      type_q  <= type_d;
      decl_q  <= decl_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== rtl/cseg_fifo.sv =====
// Short descriptor queue between the front and back parts.
module cseg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cseg_pkg::push_t       push_i,
  output logic                  full_o,
  output cseg_pkg::head_t       head_o,
  input  logic                  pop_i
);

  cseg_pkg::entry_t                   mem_q [cseg_pkg::FIFO_DEPTH];
  logic [cseg_pkg::FIFO_AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [cseg_pkg::FIFO_AW:0]         count_q;
  logic                               do_push, do_pop;

  assign full_o       = count_q == (cseg_pkg::FIFO_AW + 1)'(cseg_pkg::FIFO_DEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== rtl/cseg_back.sv =====
// Back part: expands queued descriptors into result beats behind an output register.
module cseg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cseg_pkg::head_t       head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic                  is_plain_o,
  output logic [7:0]            seg_type_o,
  output logic [10:0]           seg_length_o,
  output logic [7:0]            out_byte_o,
  output logic                  seg_end_o,
  output logic                  truncated_o,
  output logic                  last_o
);

  logic [2:0]   step_q, step_d;
  logic         valid_q;
  logic         load;
  logic         b_kind, b_plain, b_end, b_trunc, b_last;
  logic [7:0]   b_type, b_byte;
  logic [10:0]  b_len;
  logic [1:0]   held_idx;
  cseg_pkg::entry_t e;

  logic         kind_q, plain_q, end_q, trunc_q, last_q;
  logic [7:0]   type_q, byte_q;
  logic [10:0]  len_q;

  assign e        = head_i.entry;
  assign load     = head_i.valid && (!valid_q || !out_stall_i);
  assign held_idx = step_q[1:0] - 2'd1;

  always_comb begin
    b_kind  = 1'b0;
    b_plain = e.is_plain;
    b_type  = 8'd0;
    b_len   = 11'd0;
    b_byte  = 8'd0;
    b_end   = 1'b0;
    b_trunc = 1'b0;
    b_last  = 1'b1;
    case (e.op)
      cseg_pkg::OP_HEADER: begin
        b_type  = e.seg_type;
        b_len   = e.seg_length;
        b_trunc = e.truncated;
      end
      cseg_pkg::OP_PAYLOAD: begin
        b_kind = 1'b1;
        b_byte = e.data;
        b_end  = e.seg_end;
      end
      cseg_pkg::OP_SWITCH: begin
        if (step_q == 3'd0) begin
          b_len  = e.seg_length;
          b_last = 1'b0;
        end else if (step_q <= {1'b0, e.n_held}) begin
          b_kind = 1'b1;
          b_byte = e.held[held_idx];
          b_last = 1'b0;
        end else begin
          b_kind = 1'b1;
          b_byte = e.data;
          b_end  = e.seg_end;
        end
      end
      default: begin
        b_last = 1'b1;
      end
    endcase
  end

  assign pop_o  = load && b_last;
  assign step_d = !load ? step_q : (b_last ? 3'd0 : step_q + 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= b_kind;
      plain_q <= b_plain;
      type_q  <= b_type;
      len_q   <= b_len;
      byte_q  <= b_byte;
      end_q   <= b_end;
      trunc_q <= b_trunc;
      last_q  <= b_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign is_plain_o   = plain_q;
  assign seg_type_o   = type_q;
  assign seg_length_o = len_q;
  assign out_byte_o   = byte_q;
  assign seg_end_o    = end_q;
  assign truncated_o  = trunc_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/control_segment_deframer.sv =====
// Top level of the control segment deframer.
// Accepts one payload byte and emits one result beat per cycle unless stalled. A byte
// yields zero or one beat, except the byte at which a segment falls back to plain data,
// which yields a header and up to four data beats (the held magic bytes and itself); the
// four-entry descriptor queue absorbs such bursts, and input stalls only when it is full.
module control_segment_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         magic_word_we_i,
  input  logic [31:0]  magic_word_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  input  logic [10:0]  packet_len_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         kind_o,
  output logic         is_plain_o,
  output logic [7:0]   seg_type_o,
  output logic [10:0]  seg_length_o,
  output logic [7:0]   out_byte_o,
  output logic         seg_end_o,
  output logic         truncated_o,
  output logic         last_o
);

  cseg_pkg::push_t push;
  cseg_pkg::head_t head;
  logic            full;
  logic            pop;

  cseg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .magic_word_we_i (magic_word_we_i),
    .magic_word_i    (magic_word_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .packet_len_i    (packet_len_i),
    .full_i          (full),
    .push_o          (push)
  );

  cseg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  cseg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .is_plain_o   (is_plain_o),
    .seg_type_o   (seg_type_o),
    .seg_length_o (seg_length_o),
    .out_byte_o   (out_byte_o),
    .seg_end_o    (seg_end_o),
    .truncated_o  (truncated_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/control_segment_deframer_test.sv =====
// Self-checking testbench for the control segment deframer: random packets, stalls, checks.
module control_segment_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;
  localparam int unsigned MAX_LEN = 1478;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned DRAIN = 16;
  localparam int unsigned PHASE_BYTES = 42;
  localparam int unsigned NUM_SETTINGS = 6;
  localparam logic [31:0] FIRST_MAGIC = 32'hC35A_0F96;

  typedef struct packed {
    logic        kind;
    logic        is_plain;
    logic [7:0]  seg_type;
    logic [10:0] seg_length;
    logic [7:0]  out_byte;
    logic        seg_end;
    logic        truncated;
    logic        last;
  } beat_t;

  class segment_scoreboard;
    logic [31:0] magic;
    logic [10:0] byte_pos;
    logic [10:0] seg_start;
    cseg_pkg::phase_e phase;
    logic [7:0]  held [3];
    logic [7:0]  cur_type;
    logic [31:0] decl_len;
    logic [10:0] pay_left;
    beat_t       due_beats [$];
    int unsigned errors;
    int unsigned beats_checked;
    int unsigned ctrl_headers;
    int unsigned plain_headers;
    int unsigned cut_headers;

    function new();
      magic = '0;
      byte_pos = '0;
      seg_start = '0;
      phase = cseg_pkg::PH_HEADER;
      held = '{default: 8'h00};
      cur_type = '0;
      decl_len = '0;
      pay_left = '0;
      errors = 0;
      beats_checked = 0;
      ctrl_headers = 0;
      plain_headers = 0;
      cut_headers = 0;
    endfunction

    function void set_magic(logic [31:0] value);
      magic = value;
    endfunction

    function int unsigned pending();
      return due_beats.size();
    endfunction

    function beat_t mk(logic kind, logic plain, logic [7:0] typ, logic [10:0] len,
                       logic [7:0] data, logic seg_end, logic trunc);
      beat_t b;
      b.kind = kind;
      b.is_plain = plain;
      b.seg_type = typ;
      b.seg_length = len;
      b.out_byte = data;
      b.seg_end = seg_end;
      b.truncated = trunc;
      b.last = 1'b0;
      return b;
    endfunction

    function void take_byte(logic [7:0] d, logic [10:0] plen);
      int unsigned pos, start, off, want, len, rem, i;
      longint      lim;
      bit [63:0]   clamp;
      bit          at_end, went_plain;
      beat_t       burst [$];
      pos = 32'(byte_pos);
      start = 32'(seg_start);
      at_end = (pos + 1 >= plen);
      went_plain = 1'b0;
      if (start > pos) start = pos;
      case (phase)
        cseg_pkg::PH_HEADER: begin
          off = pos - start;
          if (off > 8) off = 8;
          if (off < 4) begin
            want = (magic >> (24 - 8 * off)) & 32'hFF;
            if ((off == 0 && plen < 9) || d != want) begin
              len = at_end ? off + 1 : plen - start;
              went_plain = 1'b1;
              burst.push_back(mk(KIND_HEADER, 1'b1, 8'h00, len[10:0], 8'h00, 1'b0, 1'b0));
              for (i = 0; i < off && i < 3; i++) begin
                burst.push_back(mk(KIND_PAYLOAD, 1'b1, 8'h00, 11'd0, held[i], 1'b0, 1'b0));
              end
              burst.push_back(mk(KIND_PAYLOAD, 1'b1, 8'h00, 11'd0, d, at_end, 1'b0));
              phase = cseg_pkg::PH_PLAIN;
              plain_headers++;
            end else if (off < 3) begin
              held[off] = d;
            end
          end else if (off == 4) begin
            cur_type = d;
          end else if (off == 5) begin
            decl_len = {24'd0, d};
          end else begin
            decl_len = {decl_len[23:0], d};
          end
          if (!went_plain) begin
            if (off == 8) begin
              lim = longint'(cseg_pkg::LIM_BASE) - longint'(start);
              if (lim < 0) lim = 0;
              clamp = {32'd0, decl_len};
              if (clamp > lim) clamp = lim;
              rem = at_end ? 0 : plen - (pos + 1);
              len = (clamp < rem) ? int'(clamp) : rem;
              burst.push_back(mk(KIND_HEADER, 1'b0, cur_type, len[10:0], 8'h00, 1'b0, 1'b0));
              ctrl_headers++;
              if (len == 0) begin
                seg_start = 11'(pos + 1);
              end else begin
                pay_left = 11'(len);
                phase = cseg_pkg::PH_PAYLOAD;
              end
            end else if (at_end) begin
              burst.push_back(mk(KIND_HEADER, 1'b0, (off >= 4) ? cur_type : 8'h00, 11'd0,
                                 8'h00, 1'b0, 1'b1));
              cut_headers++;
            end
          end
        end
        cseg_pkg::PH_PAYLOAD: begin
          if (pay_left > 0) pay_left--;
          burst.push_back(mk(KIND_PAYLOAD, 1'b0, 8'h00, 11'd0, d,
                             (pay_left == 0) || at_end, 1'b0));
          if (pay_left == 0) begin
            phase = cseg_pkg::PH_HEADER;
            seg_start = 11'(pos + 1);
          end
        end
        default: begin
          burst.push_back(mk(KIND_PAYLOAD, 1'b1, 8'h00, 11'd0, d, at_end, 1'b0));
        end
      endcase
      if (burst.size() > 0) burst[$].last = 1'b1;
      foreach (burst[k]) due_beats.push_back(burst[k]);
      if (at_end) begin
        byte_pos = '0;
        seg_start = '0;
        phase = cseg_pkg::PH_HEADER;
        pay_left = '0;
      end else begin
        byte_pos = 11'(pos + 1);
      end
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void match_beat(beat_t got);
      beat_t want;
      beats_checked++;
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = due_beats.pop_front();
      if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
      if (got.is_plain !== want.is_plain) flag("is_plain", want.is_plain, got.is_plain);
      if (got.seg_type !== want.seg_type) flag("seg_type", want.seg_type, got.seg_type);
      if (got.seg_length !== want.seg_length)
        flag("seg_length", want.seg_length, got.seg_length);
      if (got.out_byte !== want.out_byte) flag("out_byte", want.out_byte, got.out_byte);
      if (got.seg_end !== want.seg_end) flag("seg_end", want.seg_end, got.seg_end);
      if (got.truncated !== want.truncated) flag("truncated", want.truncated, got.truncated);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        magic_word_we_i;
  logic [31:0] magic_word_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic [10:0] packet_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic        is_plain_o;
  logic [7:0]  seg_type_o;
  logic [10:0] seg_length_o;
  logic [7:0]  out_byte_o;
  logic        seg_end_o;
  logic        truncated_o;
  logic        last_o;

  segment_scoreboard sb;
  logic [7:0]  pkt_bytes [$];
  logic [10:0] pkt_lens [$];
  bit          steady;
  bit          hold_req;
  int unsigned bytes_sent;
  int unsigned phase_bytes;

  control_segment_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .magic_word_we_i (magic_word_we_i),
    .magic_word_i    (magic_word_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .packet_len_i    (packet_len_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .is_plain_o      (is_plain_o),
    .seg_type_o      (seg_type_o),
    .seg_length_o    (seg_length_o),
    .out_byte_o      (out_byte_o),
    .seg_end_o       (seg_end_o),
    .truncated_o     (truncated_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(data_byte_i, packet_len_i);
      if (out_valid_o && !out_stall_i)
        sb.match_beat('{kind_o, is_plain_o, seg_type_o, seg_length_o, out_byte_o,
                        seg_end_o, truncated_o, last_o});
    end
  end

  initial begin
    int unsigned run;
    bit          st;
    run = 0;
    st = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        st = 1'b1;
        run = LONG_HOLD;
      end else if (run > 0) begin
        run--;
      end else if (steady) begin
        st = 1'b0;
      end else begin
        st = ($urandom_range(0, 99) < 35);
        if (st)
          run = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 25);
        else
          run = $urandom_range(0, 6);
      end
      out_stall_i <= st;
    end
  end

  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic [10:0] plen);
    pkt_bytes.push_back(b);
    pkt_lens.push_back(plen);
  endfunction

  function automatic void build_packet(int unsigned plen, logic [31:0] mw);
    int unsigned sel, bad, n, i;
    int          room;
    int unsigned r;
    logic [31:0] decl;
    logic [7:0]  b;
    pkt_bytes.delete();
    pkt_lens.delete();
    while (pkt_bytes.size() < plen) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 11'(plen));
      end else begin
        bad = $urandom_range(0, 3);
        for (i = 0; i < 4; i++) begin
          b = mw[31 - 8 * i -: 8];
          if (sel < 27 && i == bad) b = b ^ 8'($urandom_range(1, 255));
          add_byte(b, 11'(plen));
        end
        add_byte(8'($urandom_range(0, 255)), 11'(plen));
        room = int'(plen) - int'(pkt_bytes.size()) - 4;
        r = $urandom_range(0, 9);
        if (r < 6) decl = (room > 0) ? $urandom_range(0, room) : 0;
        else if (r == 6) decl = 0;
        else if (r == 7) decl = $urandom;
        else decl = ((room > 0) ? room : 0) + $urandom_range(1, 16);
        for (i = 0; i < 4; i++) add_byte(decl[31 - 8 * i -: 8], 11'(plen));
        n = (decl < plen) ? decl : plen;
        for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 11'(plen));
      end
    end
    while (pkt_bytes.size() > plen) begin
      void'(pkt_bytes.pop_back());
      void'(pkt_lens.pop_back());
    end
    if ($urandom_range(0, 99) < 10) begin
      for (i = 0; i + 1 < plen; i++) begin
        if ($urandom_range(0, 1)) pkt_lens[i] = 11'($urandom_range(i + 2, MAX_LEN));
      end
      pkt_lens[plen - 1] = 11'($urandom_range(1, plen));
    end
  endfunction

  task automatic send_byte(logic [7:0] d, logic [10:0] plen);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    packet_len_i <= plen;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) begin
      send_byte(pkt_bytes[i], pkt_lens[i]);
      bytes_sent++;
      phase_bytes++;
    end
  endtask

  task automatic write_magic(logic [31:0] value);
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    magic_word_we_i <= 1'b1;
    magic_word_i <= value;
    @(posedge clk_i);
    magic_word_we_i <= 1'b0;
    sb.set_magic(value);
  endtask

  initial begin
    logic [31:0] settings [NUM_SETTINGS];
    logic [7:0]  rep;
    int unsigned r, plen;
    sb = new();
    steady = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    rst_ni <= 1'b0;
    magic_word_we_i <= 1'b0;
    magic_word_i <= '0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    packet_len_i <= 11'd1;
    rep = 8'($urandom_range(0, 255));
    settings[0] = FIRST_MAGIC;
    settings[1] = 32'h0000_0000;
    settings[2] = 32'hFFFF_FFFF;
    settings[3] = $urandom;
    settings[4] = {rep, rep, rep, rep};
    settings[5] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      write_magic(settings[ph]);
      phase_bytes = 0;
      if (ph == 0) begin
        pkt_bytes.delete();
        pkt_lens.delete();
        add_byte(8'h00, 11'd1);
        add_byte(8'hFF, 11'd3);
        add_byte(8'h00, 11'd3);
        add_byte(8'h80, 11'd3);
        add_byte(8'hC3, 11'd1478);
        add_byte(8'h5A, 11'd1478);
        add_byte(8'h0F, 11'd1478);
        add_byte(8'h96, 11'd1478);
        add_byte(8'hFF, 11'd1478);
        add_byte(8'h00, 11'd1478);
        add_byte(8'h00, 11'd1478);
        add_byte(8'h00, 11'd1478);
        add_byte(8'h02, 11'd1478);
        add_byte(8'h00, 11'd1478);
        add_byte(8'hFF, 11'd1478);
        add_byte(8'hC3, 11'd12);
        add_byte(8'hC3, 11'd9);
        add_byte(8'h5A, 11'd9);
        add_byte(8'h0F, 11'd9);
        add_byte(8'h96, 11'd9);
        add_byte(8'h00, 11'd9);
        add_byte(8'h00, 11'd9);
        add_byte(8'h00, 11'd9);
        add_byte(8'h01, 11'd9);
        add_byte(8'h00, 11'd9);
        send_packet();
      end
      if (ph == 1 || ph == 4) begin
        steady = 1'b1;
        hold_req = 1'b1;
        build_packet(40, settings[ph]);
        send_packet();
      end
      while (phase_bytes < PHASE_BYTES) begin
        steady = ($urandom_range(0, 99) < 20);
        r = $urandom_range(0, 99);
        if (r < 10) plen = $urandom_range(1, 8);
        else if (r < 85) plen = $urandom_range(9, 48);
        else plen = $urandom_range(49, 120);
        build_packet(plen, settings[ph]);
        send_packet();
      end
      steady = 1'b0;
      in_valid_i <= 1'b0;
    end

    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d bytes under %0d magic settings, checked %0d result beats.",
             bytes_sent, NUM_SETTINGS, sb.beats_checked);
    $display("Covered %0d control headers, %0d plain fallbacks, %0d cut-short headers.",
             sb.ctrl_headers, sb.plain_headers, sb.cut_headers);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
